// File: rtl/i2cq_pkg.sv
// Package with the beat types and constants of the I2C slave command queue.
package i2cq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int SLOT_BYTES          = 5;
  localparam int SLOT_W              = 8 * SLOT_BYTES;
  localparam int STAGE_W             = 3;

  localparam logic [2:0] REQ_ADDR_WRITE = 3'd0;
  localparam logic [2:0] REQ_ADDR_READ  = 3'd1;
  localparam logic [2:0] REQ_DATA_BYTE  = 3'd2;
  localparam logic [2:0] REQ_TX_ACK     = 3'd3;
  localparam logic [2:0] REQ_TX_NACK    = 3'd4;
  localparam logic [2:0] REQ_POP        = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic       tx_valid;
    logic [4:0] tx_byte;
    logic       cmd_valid;
    logic [7:0] cmd_opcode;
    logic [7:0] cmd_arg_a;
    logic [7:0] cmd_arg_b;
    logic [7:0] cmd_arg_c;
    logic [7:0] cmd_arg_d;
  } out_beat_t;

endpackage

// File: rtl/i2cq_slot_ram.sv
// Command slot memory with one registered read port, one write port and per-slot valid bits.
module i2cq_slot_ram #(
  parameter int DEPTH = i2cq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [i2cq_pkg::SLOT_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [i2cq_pkg::SLOT_W-1:0] wr_data
);

  logic [i2cq_pkg::SLOT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [i2cq_pkg::SLOT_W-1:0] rd_data_r;
  logic                        rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // A slot that was never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

// File: rtl/i2c_slave_command_queue_top.sv
// Top level of the I2C slave command queue: control, pointers, slot memory and result register.
// Each event is accepted in ST_IDLE, where the accept cycle issues the slot read; ST_EXEC then
// applies the event and loads the result register from the registered slot memory read.
// A new event is taken only once the last one has completed; a waiting result holds ST_EXEC.
// Synchronous reset clears pointers, count, stage and slot valid bits,
// so every slot reads as zero after reset without a clearing pass.
module i2c_slave_command_queue_top #(
  parameter int QUEUE_DEPTH = i2cq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cq_pkg::out_beat_t out_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Pointers, occupancy and the byte position inside the open slot.
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [i2cq_pkg::STAGE_W-1:0] stage_r, stage_nxt;

  // The accepted event, held while it is applied.
  i2cq_pkg::in_beat_t req_r;

  // Result register that parts the input side from the consumer.
  logic                out_valid_r, out_valid_nxt;
  i2cq_pkg::out_beat_t out_data_r, out_data_nxt;

  logic                        in_fire;
  logic                        exec_fire;
  logic [IDX_W-1:0]            rd_addr;
  logic [i2cq_pkg::SLOT_W-1:0] slot_rd;
  logic [i2cq_pkg::SLOT_W-1:0] slot_wr;
  logic                        mem_wr_en;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // The execute state completes once the result register is free or being emptied.
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  // A pop reads the slot the read pointer moves to; every other event reads the open slot,
  // which a data byte modifies and writes back. The FSM keeps one event in flight, so the
  // write back always lands before the next read is issued and no forwarding is needed.
  assign rd_addr = (in_data.req_type == i2cq_pkg::REQ_POP) ? next_idx(rd_idx_r) : wr_idx_r;

  i2cq_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_slot_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (slot_rd),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_idx_r),
    .wr_data (slot_wr)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Apply the held event. Nothing changes unless the execute state completes.
  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    occ_nxt      = occ_r;
    stage_nxt    = stage_r;
    mem_wr_en    = 1'b0;
    slot_wr      = slot_rd;
    out_data_nxt = out_data_r;

    for (int j = 0; j < i2cq_pkg::SLOT_BYTES; j++) begin
      if (stage_r == i2cq_pkg::STAGE_W'(j)) begin
        slot_wr[8*j +: 8] = req_r.data_byte;
      end
    end

    if (exec_fire) begin
      out_data_nxt = '0;
      if (req_r.req_type == i2cq_pkg::REQ_POP) begin
        // Popping an empty queue gives an all-zero result.
        if (occ_r != '0) begin
          occ_nxt                 = occ_r - 1'b1;
          rd_idx_nxt              = next_idx(rd_idx_r);
          out_data_nxt.cmd_valid  = 1'b1;
          out_data_nxt.cmd_opcode = slot_rd[7:0];
          out_data_nxt.cmd_arg_a  = slot_rd[15:8];
          out_data_nxt.cmd_arg_b  = slot_rd[23:16];
          out_data_nxt.cmd_arg_c  = slot_rd[31:24];
          out_data_nxt.cmd_arg_d  = slot_rd[39:32];
        end
      end else if (occ_r != FULL_CNT) begin
        // A full queue ignores every bus event.
        case (req_r.req_type) inside
          i2cq_pkg::REQ_ADDR_WRITE: begin
            stage_nxt  = '0;
            occ_nxt    = occ_r + 1'b1;
            wr_idx_nxt = next_idx(wr_idx_r);
          end
          i2cq_pkg::REQ_ADDR_READ, i2cq_pkg::REQ_TX_ACK: begin
            out_data_nxt.tx_valid = 1'b1;
            out_data_nxt.tx_byte  = 5'(occ_r);
          end
          i2cq_pkg::REQ_DATA_BYTE: begin
            // Bytes beyond the fifth are dropped until the next address-write.
            if (stage_r < i2cq_pkg::STAGE_W'(i2cq_pkg::SLOT_BYTES)) begin
              mem_wr_en = 1'b1;
              stage_nxt = stage_r + 1'b1;
            end
          end
          default: begin
            // Transmit NACK and undefined codes change nothing.
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      occ_r       <= '0;
      stage_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      occ_r       <= occ_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The count never passes the queue depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy exceeds queue depth");

  // The byte position never passes the slot size.
  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r <= i2cq_pkg::STAGE_W'(i2cq_pkg::SLOT_BYTES))
    else $error("byte stage exceeds slot size");

  // A completed pop on a nonempty queue lowers the count by one and shows a command.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && req_r.req_type == i2cq_pkg::REQ_POP && occ_r != '0) |=>
      (occ_r == $past(occ_r) - 1'b1) && out_valid && out_data.cmd_valid)
    else $error("pop did not update count or result");

  // A result never carries both a count and a command.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.tx_valid && out_data.cmd_valid))
    else $error("result carries both a count and a command");

endmodule
